// ===== rtl/wdtkl_pkg.sv =====
`timescale 1ns / 1ps

package wdtkl_pkg;

  localparam int unsigned CountWidthDef = 32;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned OffWidth  = 12;
  localparam int unsigned OpWidth   = 2;

  // item opcodes
  localparam logic [OpWidth-1:0] OP_READ  = 2'd0;
  localparam logic [OpWidth-1:0] OP_WRITE = 2'd1;
  localparam logic [OpWidth-1:0] OP_TICK  = 2'd2;

  // register window byte offsets
  localparam logic [OffWidth-1:0] OFF_CTRL   = 12'h000;
  localparam logic [OffWidth-1:0] OFF_LOAD   = 12'h004;
  localparam logic [OffWidth-1:0] OFF_COUNT  = 12'h008;
  localparam logic [OffWidth-1:0] OFF_STATUS = 12'h00C;
  localparam logic [OffWidth-1:0] OFF_KEY    = 12'h010;

  // control bit positions
  localparam int unsigned CtlEn    = 0;
  localparam int unsigned CtlIntEn = 1;
  localparam int unsigned CtlRstEn = 2;
  localparam int unsigned CtlLock  = 3;

  localparam logic [DataWidth-1:0] KEY_FEED = 32'h5A5A_5A5A;
  localparam logic [DataWidth-1:0] KEY_LOCK = 32'h1ACC_E551;

  localparam logic [DataWidth-1:0] LoadReset = 32'h0000_FFFF;

  typedef struct packed {
    logic [OpWidth-1:0]   opcode;
    logic [OffWidth-1:0]  offset;
    logic [DataWidth-1:0] write_data;
  } wdtkl_in_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 irq_level;
    logic                 reset_request;
    logic                 bad_offset;
  } wdtkl_out_t;

endpackage

// ===== rtl/watchdog_timer_with_key_lock_core.sv =====
`timescale 1ns / 1ps

// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o   in_data_i  (opcode, offset, write_data)
// out      output     out_valid_o / out_stall_i out_data_o (read_data, irq_level,
//                                                reset_request, bad_offset)
//
// one beat per cycle on each side while not stalled; a result appears in the cycle after its input beat
// registers and count update at the input beat, the result sits in one output register
// in_stall_o follows out_stall_i only while the output register holds a result
// reset clears control, status and arming; load and count come up at 0xFFFF

module watchdog_timer_with_key_lock_core
  import wdtkl_pkg::*;
#(
  parameter int unsigned CountWidth = CountWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  wdtkl_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output wdtkl_out_t out_data_o
);

  logic [3:0]            ctrl_q, ctrl_d;
  logic [DataWidth-1:0]  load_q, load_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  tmo_q, tmo_d;
  logic                  armed_q, armed_d;
  logic                  out_valid_q, out_valid_d;
  wdtkl_out_t            out_q, out_d;

  logic                  accept;
  logic                  off_ok;
  logic [CountWidth-1:0] reload_cnt;
  logic [63:0]           cnt_wide;
  logic [DataWidth-1:0]  wd;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign wd         = in_data_i.write_data;
  assign reload_cnt = CountWidth'(load_q);
  assign cnt_wide   = 64'(cnt_q);

  always_comb begin
    off_ok = (in_data_i.offset == OFF_CTRL)   || (in_data_i.offset == OFF_LOAD) ||
             (in_data_i.offset == OFF_COUNT)  || (in_data_i.offset == OFF_STATUS) ||
             (in_data_i.offset == OFF_KEY);
  end

  always_comb begin
    ctrl_d  = ctrl_q;
    load_d  = load_q;
    cnt_d   = cnt_q;
    tmo_d   = tmo_q;
    armed_d = armed_q;
    out_d   = '0;

    case (in_data_i.opcode)
      OP_READ: begin
        out_d.bad_offset = ~off_ok;
        case (in_data_i.offset)
          OFF_CTRL:   out_d.read_data = {{(DataWidth-4){1'b0}}, ctrl_q};
          OFF_LOAD:   out_d.read_data = load_q;
          OFF_COUNT:  out_d.read_data = cnt_wide[DataWidth-1:0];
          OFF_STATUS: out_d.read_data = {{(DataWidth-1){1'b0}}, tmo_q};
          default:    out_d.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        out_d.bad_offset = ~off_ok;
        case (in_data_i.offset)
          OFF_CTRL: begin
            if (!ctrl_q[CtlLock]) begin
              ctrl_d = {1'b0, wd[CtlRstEn:CtlEn]};
              if (!ctrl_q[CtlEn] && wd[CtlEn]) begin
                cnt_d   = reload_cnt;
                armed_d = 1'b1;
              end else if (ctrl_q[CtlEn] && !wd[CtlEn]) begin
                armed_d = 1'b0;
              end
            end
          end
          OFF_LOAD: load_d = wd;
          OFF_STATUS: begin
            if (wd[0]) tmo_d = 1'b0;
          end
          OFF_KEY: begin
            if (wd == KEY_FEED) begin
              cnt_d = reload_cnt;
              tmo_d = 1'b0;
              if (ctrl_q[CtlEn]) armed_d = 1'b1;
            end else if (wd == KEY_LOCK) begin
              ctrl_d[CtlLock] = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (armed_q) begin
          // count of one or zero expires on this tick
          if (cnt_q[CountWidth-1:1] == '0) begin
            cnt_d               = '0;
            tmo_d               = 1'b1;
            armed_d             = 1'b0;
            out_d.reset_request = ctrl_q[CtlRstEn];
          end else begin
            cnt_d = cnt_q - CountWidth'(1);
          end
        end
      end
      default: ;
    endcase

    out_d.irq_level = tmo_d & ctrl_d[CtlIntEn];
  end

  assign out_valid_d = accept | in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      load_q      <= LoadReset;
      cnt_q       <= CountWidth'(LoadReset);
      tmo_q       <= 1'b0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        ctrl_q  <= ctrl_d;
        load_q  <= load_d;
        cnt_q   <= cnt_d;
        tmo_q   <= tmo_d;
        armed_q <= armed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/watchdog_timer_with_key_lock_core_test.sv =====
`timescale 1ns / 1ps

module watchdog_timer_with_key_lock_core_test;
  import wdtkl_pkg::*;

  localparam logic [OpWidth-1:0] OP_UNUSED = 2'd3;

  localparam logic [DataWidth-1:0] CtlRunAll =
      (32'd1 << CtlEn) | (32'd1 << CtlIntEn) | (32'd1 << CtlRstEn);
  localparam logic [DataWidth-1:0] CtlRunIrq = (32'd1 << CtlEn) | (32'd1 << CtlIntEn);
  localparam logic [DataWidth-1:0] CtlHalt = '0;
  localparam logic [DataWidth-1:0] StatusClear = 32'd1;

  localparam int unsigned RandomItems = 450;
  localparam int unsigned LockAt = 430;

  class watchdog_shadow;
    logic [3:0]           ctl;
    logic [DataWidth-1:0] reload;
    logic [DataWidth-1:0] count;
    bit                   timed_out;
    bit                   armed;
    wdtkl_out_t           expected_results[$];
    int unsigned          mismatches;

    function new();
      ctl = '0;
      reload = LoadReset;
      count = LoadReset;
      timed_out = 1'b0;
      armed = 1'b0;
      mismatches = 0;
    endfunction

    function void record_command(wdtkl_in_t cmd);
      wdtkl_out_t res;
      logic       was_en;
      res = '0;
      was_en = ctl[CtlEn];
      case (cmd.opcode)
        OP_READ: begin
          case (cmd.offset)
            OFF_CTRL:   res.read_data = 32'(ctl);
            OFF_LOAD:   res.read_data = reload;
            OFF_COUNT:  res.read_data = count;
            OFF_STATUS: res.read_data = 32'(timed_out);
            OFF_KEY:    res.read_data = '0;
            default:    res.bad_offset = 1'b1;
          endcase
        end
        OP_WRITE: begin
          case (cmd.offset)
            OFF_CTRL: begin
              if (!ctl[CtlLock]) begin
                ctl = {1'b0, cmd.write_data[CtlRstEn:CtlEn]};
                if (!was_en && ctl[CtlEn]) begin
                  count = reload;
                  armed = 1'b1;
                end else if (was_en && !ctl[CtlEn]) begin
                  armed = 1'b0;
                end
              end
            end
            OFF_LOAD: reload = cmd.write_data;
            OFF_COUNT: ;
            OFF_STATUS: begin
              if (cmd.write_data[0]) timed_out = 1'b0;
            end
            OFF_KEY: begin
              if (cmd.write_data == KEY_FEED) begin
                count = reload;
                timed_out = 1'b0;
                if (ctl[CtlEn]) armed = 1'b1;
              end else if (cmd.write_data == KEY_LOCK) begin
                ctl[CtlLock] = 1'b1;
              end
            end
            default: res.bad_offset = 1'b1;
          endcase
        end
        OP_TICK: begin
          if (armed) begin
            if (count <= 32'd1) begin
              count = '0;
              timed_out = 1'b1;
              armed = 1'b0;
              res.reset_request = ctl[CtlRstEn];
            end else begin
              count = count - 32'd1;
            end
          end
        end
        default: ;
      endcase
      res.irq_level = timed_out & ctl[CtlIntEn];
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [DataWidth-1:0] want,
                                logic [DataWidth-1:0] got);
      if (got !== want) begin
        $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(wdtkl_out_t got);
      wdtkl_out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t ns: result beat expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("irq_level", 32'(want.irq_level), 32'(got.irq_level));
      compare_field("reset_request", 32'(want.reset_request), 32'(got.reset_request));
      compare_field("bad_offset", 32'(want.bad_offset), 32'(got.bad_offset));
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  wdtkl_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  wdtkl_out_t out_data_o;

  watchdog_shadow shadow;
  bit             steady_flow = 1'b0;

  watchdog_timer_with_key_lock_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // mostly short gaps, a few long ones, none during a steady stretch
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [OffWidth-1:0] reg_offset();
    case ($urandom_range(0, 4))
      0:       return OFF_CTRL;
      1:       return OFF_LOAD;
      2:       return OFF_COUNT;
      3:       return OFF_STATUS;
      default: return OFF_KEY;
    endcase
  endfunction

  function automatic wdtkl_in_t random_command();
    wdtkl_in_t   c;
    int unsigned r;
    r = $urandom_range(0, 99);
    c.opcode = OP_TICK;
    c.offset = OffWidth'($urandom);
    c.write_data = $urandom;
    if (r >= 40 && r < 58) begin
      c.opcode = OP_READ;
      c.offset = reg_offset();
    end else if (r >= 58 && r < 88) begin
      c.opcode = OP_WRITE;
      c.offset = reg_offset();
      // small reloads so timeouts come often
      case (c.offset)
        OFF_CTRL: if ($urandom_range(0, 3) != 0) c.write_data = $urandom_range(0, 7);
        OFF_LOAD: if ($urandom_range(0, 4) != 0) c.write_data = $urandom_range(0, 24);
        OFF_KEY:  if ($urandom_range(0, 1) != 0) c.write_data = KEY_FEED;
        default: ;
      endcase
      // the lock key is kept for the tail of the run
      if (c.write_data == KEY_LOCK) c.write_data[0] = ~c.write_data[0];
    end else if (r >= 88 && r < 95) begin
      c.opcode = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
      if (c.offset <= OFF_KEY && c.offset[1:0] == 2'b00) c.offset[OffWidth-1] = 1'b1;
      if (c.write_data == KEY_LOCK) c.write_data[0] = ~c.write_data[0];
    end else if (r >= 95) begin
      c.opcode = OP_UNUSED;
    end
    return c;
  endfunction

  task automatic drive_command(wdtkl_in_t cmd);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    shadow.record_command(cmd);
  endtask

  task automatic drive_fields(logic [OpWidth-1:0] op, logic [OffWidth-1:0] off,
                              logic [DataWidth-1:0] data);
    wdtkl_in_t cmd;
    cmd.opcode = op;
    cmd.offset = off;
    cmd.write_data = data;
    drive_command(cmd);
  endtask

  initial begin : stall_gen
    int unsigned hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold = idle_len();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) shadow.check_response(out_data_o);
  end

  initial begin : stimulus
    wdtkl_in_t cmd;
    shadow = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, key readback, bad offsets, unused opcode, idle tick
    drive_fields(OP_READ, OFF_CTRL, '0);
    drive_fields(OP_READ, OFF_LOAD, '0);
    drive_fields(OP_READ, OFF_COUNT, '0);
    drive_fields(OP_READ, OFF_STATUS, '0);
    drive_fields(OP_READ, OFF_KEY, 32'hFFFF_FFFF);
    drive_fields(OP_READ, 12'hFFF, 32'hFFFF_FFFF);
    drive_fields(OP_WRITE, 12'h014, 32'hFFFF_FFFF);
    drive_fields(OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF);
    drive_fields(OP_TICK, 12'hFFF, '0);
    // arm, repeated enable keeps the count, run into a timeout with reset request
    drive_fields(OP_WRITE, OFF_LOAD, 32'd3);
    drive_fields(OP_WRITE, OFF_CTRL, CtlRunAll);
    drive_fields(OP_TICK, OFF_CTRL, '0);
    drive_fields(OP_WRITE, OFF_CTRL, 32'hFFFF_FFF0 | CtlRunAll);
    drive_fields(OP_TICK, OFF_CTRL, '0);
    drive_fields(OP_TICK, OFF_CTRL, '0);
    drive_fields(OP_READ, OFF_STATUS, '0);
    drive_fields(OP_READ, OFF_COUNT, '0);
    drive_fields(OP_WRITE, OFF_STATUS, StatusClear);
    drive_fields(OP_TICK, OFF_CTRL, '0);
    // feed after a timeout re-arms
    drive_fields(OP_WRITE, OFF_KEY, KEY_FEED);
    // zero reload, feed while disabled, then arm with zero count
    drive_fields(OP_WRITE, OFF_LOAD, '0);
    drive_fields(OP_WRITE, OFF_CTRL, CtlHalt);
    drive_fields(OP_WRITE, OFF_KEY, KEY_FEED);
    drive_fields(OP_WRITE, OFF_CTRL, CtlRunIrq);
    drive_fields(OP_TICK, OFF_CTRL, '0);
    drive_fields(OP_WRITE, OFF_COUNT, 32'h1234_5678);
    drive_fields(OP_WRITE, OFF_KEY, 32'h1234_5678);

    for (int i = 0; i < RandomItems; i++) begin
      steady_flow = (i >= 150 && i < 230);
      if (i == LockAt) begin
        cmd.opcode = OP_WRITE;
        cmd.offset = OFF_KEY;
        cmd.write_data = KEY_LOCK;
      end else begin
        cmd = random_command();
      end
      drive_command(cmd);
    end
    steady_flow = 1'b0;
    in_valid_i <= 1'b0;

    while (shadow.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
